### hdl/php_pkg.sv
// ----------------------------------------------------------------------------
// php_pkg
// shared types, constants and timestamp decode for the pes header parser
// ----------------------------------------------------------------------------
package php_pkg;

  localparam int unsigned COUNT_BITS = 17;
  localparam int unsigned WIDE_BITS  = (COUNT_BITS > 17) ? COUNT_BITS : 17;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [WIDE_BITS-1:0]  PAYLEN_MAX = WIDE_BITS'(131071);

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_SHORT_PKT = 3'd1;
  localparam logic [2:0] STAT_NO_OPT    = 3'd2;
  localparam logic [2:0] STAT_SHORT_EXT = 3'd3;
  localparam logic [2:0] STAT_SHORT_HDR = 3'd4;

  localparam logic [7:0] SID_PRIV1   = 8'hBD;
  localparam logic [7:0] SID_PADDING = 8'hBE;
  localparam logic [7:0] SID_PRIV2   = 8'hBF;
  localparam logic [7:0] SID_LAST    = 8'hEF;

  localparam int unsigned OUT_BITS = 128;

  typedef struct packed {
    logic [COUNT_BITS-1:0] total;
    logic [7:0]            sid;
    logic [15:0]           len;
    logic [7:0]            ext;
    logic [7:0]            ptsdts;
    logic [7:0]            hdr_len;
    logic [39:0]           stamp_a;
    logic [39:0]           stamp_b;
  } php_rec_t;

  typedef struct packed {
    logic [16:0] payload_length;
    logic [8:0]  payload_offset;
    logic [32:0] dts_value;
    logic [32:0] pts_value;
    logic [5:0]  flag_bits;
    logic [1:0]  scrambling;
    logic [15:0] pes_length;
    logic [7:0]  stream_id;
    logic [2:0]  status;
  } php_res_t;

  function automatic logic [32:0] stamp_from(input logic [39:0] v);
    return {v[35:33], v[31:24], v[23:17], v[15:8], v[7:1]};
  endfunction

endpackage

### hdl/php_front.sv
// ----------------------------------------------------------------------------
// php_front
// byte counter and header field capture, emits one packet record per last beat
// ----------------------------------------------------------------------------
module php_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output logic               push_o,
  output php_pkg::php_rec_t  rec_o
);

  logic [php_pkg::COUNT_BITS-1:0] count_q, count_d, count_inc;
  logic [7:0]  sid_q, sid_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  ext_q, ext_d;
  logic [7:0]  ptsdts_q, ptsdts_d;
  logic [7:0]  hlen_q, hlen_d;
  logic [39:0] sa_q, sa_d;
  logic [39:0] sb_q, sb_d;

  always_comb begin
    count_inc = (count_q == php_pkg::CNT_MAX) ? count_q : count_q + 1'b1;
    sid_d    = sid_q;
    len_d    = len_q;
    ext_d    = ext_q;
    ptsdts_d = ptsdts_q;
    hlen_d   = hlen_q;
    sa_d     = sa_q;
    sb_d     = sb_q;
    if (count_q == php_pkg::COUNT_BITS'(3)) sid_d = byte_i;
    if (count_q == php_pkg::COUNT_BITS'(4)) len_d[15:8] = byte_i;
    if (count_q == php_pkg::COUNT_BITS'(5)) len_d[7:0] = byte_i;
    if (count_q == php_pkg::COUNT_BITS'(6)) ext_d = byte_i;
    if (count_q == php_pkg::COUNT_BITS'(7)) ptsdts_d = byte_i;
    if (count_q == php_pkg::COUNT_BITS'(8)) hlen_d = byte_i;
    for (int k = 0; k < 5; k++) begin
      if (count_q == php_pkg::COUNT_BITS'(9 + k)) sa_d[8*(4-k) +: 8] = byte_i;
      if (count_q == php_pkg::COUNT_BITS'(14 + k)) sb_d[8*(4-k) +: 8] = byte_i;
    end
    count_d = count_inc;
  end

  assign push_o = beat_i && last_i;

  always_comb begin
    rec_o.total   = count_d;
    rec_o.sid     = sid_d;
    rec_o.len     = len_d;
    rec_o.ext     = ext_d;
    rec_o.ptsdts  = ptsdts_d;
    rec_o.hdr_len = hlen_d;
    rec_o.stamp_a = sa_d;
    rec_o.stamp_b = sb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sid_q    <= '0;
      len_q    <= '0;
      ext_q    <= '0;
      ptsdts_q <= '0;
      hlen_q   <= '0;
      sa_q     <= '0;
      sb_q     <= '0;
    end else if (beat_i) begin
      if (last_i) begin
        count_q  <= '0;
        sid_q    <= '0;
        len_q    <= '0;
        ext_q    <= '0;
        ptsdts_q <= '0;
        hlen_q   <= '0;
        sa_q     <= '0;
        sb_q     <= '0;
      end else begin
        count_q  <= count_d;
        sid_q    <= sid_d;
        len_q    <= len_d;
        ext_q    <= ext_d;
        ptsdts_q <= ptsdts_d;
        hlen_q   <= hlen_d;
        sa_q     <= sa_d;
        sb_q     <= sb_d;
      end
    end
  end

  property p_count_saturates;
    @(posedge clk_i) disable iff (!rst_ni)
      (beat_i && !last_i && count_q == php_pkg::CNT_MAX) |=> count_q == php_pkg::CNT_MAX;
  endproperty
  a_count_saturates: assert property (p_count_saturates) else $error("count wrapped");

  property p_clear_after_last;
    @(posedge clk_i) disable iff (!rst_ni)
      (beat_i && last_i) |=> (count_q == '0 && sid_q == '0 && sa_q == '0);
  endproperty
  a_clear_after_last: assert property (p_clear_after_last) else $error("state not cleared");

  property p_count_steps;
    @(posedge clk_i) disable iff (!rst_ni)
      !beat_i |=> $stable(count_q);
  endproperty
  a_count_steps: assert property (p_count_steps) else $error("count moved without beat");

endmodule

### hdl/php_queue.sv
// ----------------------------------------------------------------------------
// php_queue
// two-entry record queue between the capture front and the result back
// ----------------------------------------------------------------------------
module php_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  php_pkg::php_rec_t  rec_i,
  output logic               full_o,
  output logic               empty_o,
  input  logic               pop_i,
  output php_pkg::php_rec_t  rec_o
);

  php_pkg::php_rec_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("push into full queue");

  property p_no_underflow;
    @(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o;
  endproperty
  a_no_underflow: assert property (p_no_underflow) else $error("pop from empty queue");

  property p_cnt_range;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3;
  endproperty
  a_cnt_range: assert property (p_cnt_range) else $error("queue count out of range");

endmodule

### hdl/php_back.sv
// ----------------------------------------------------------------------------
// php_back
// classifies a packet record, decodes timestamps and holds the result beat
// ----------------------------------------------------------------------------
module php_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  php_pkg::php_rec_t  rec_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               ready_i,
  output php_pkg::php_res_t  res_o
);

  php_pkg::php_res_t res_d, res_q;
  logic valid_q;
  logic [php_pkg::WIDE_BITS-1:0] total_w, poff_w, rem_w;
  logic has_pts, has_dts, sid_stop;

  assign pop_o   = !empty_i && (!valid_q || ready_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    total_w  = php_pkg::WIDE_BITS'(rec_i.total);
    poff_w   = php_pkg::WIDE_BITS'(rec_i.hdr_len) + php_pkg::WIDE_BITS'(9);
    rem_w    = total_w - poff_w;
    has_pts  = rec_i.ptsdts[7];
    has_dts  = rec_i.ptsdts[6];
    sid_stop = (rec_i.sid < php_pkg::SID_PRIV1) || (rec_i.sid == php_pkg::SID_PADDING) ||
               (rec_i.sid == php_pkg::SID_PRIV2) || (rec_i.sid > php_pkg::SID_LAST);
    res_d = '0;
    res_d.stream_id  = rec_i.sid;
    res_d.pes_length = rec_i.len;
    if (total_w <= php_pkg::WIDE_BITS'(6)) begin
      res_d.status     = php_pkg::STAT_SHORT_PKT;
      res_d.stream_id  = '0;
      res_d.pes_length = '0;
    end else if (sid_stop) begin
      res_d.status = php_pkg::STAT_NO_OPT;
    end else if (total_w < php_pkg::WIDE_BITS'(9)) begin
      res_d.status = php_pkg::STAT_SHORT_EXT;
    end else begin
      res_d.scrambling = rec_i.ext[5:4];
      res_d.flag_bits  = {rec_i.ext[3:0], rec_i.ptsdts[7:6]};
      if (total_w < poff_w) begin
        res_d.status = php_pkg::STAT_SHORT_HDR;
      end else begin
        res_d.status = php_pkg::STAT_OK;
        if (has_pts) begin
          res_d.pts_value = php_pkg::stamp_from(rec_i.stamp_a);
          if (has_dts) res_d.dts_value = php_pkg::stamp_from(rec_i.stamp_b);
        end else if (has_dts) begin
          res_d.dts_value = php_pkg::stamp_from(rec_i.stamp_a);
        end
        res_d.payload_offset = poff_w[8:0];
        if (rec_i.len != '0) begin
          res_d.payload_length = {1'b0, rec_i.len};
        end else if (rem_w > php_pkg::PAYLEN_MAX) begin
          res_d.payload_length = php_pkg::PAYLEN_MAX[16:0];
        end else begin
          res_d.payload_length = rem_w[16:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  property p_short_clears_id;
    @(posedge clk_i) disable iff (!rst_ni)
      (valid_q && res_q.status == php_pkg::STAT_SHORT_PKT) |->
        (res_q.stream_id == '0 && res_q.pes_length == '0);
  endproperty
  a_short_clears_id: assert property (p_short_clears_id) else $error("short packet id");

  property p_offset_only_ok;
    @(posedge clk_i) disable iff (!rst_ni)
      (valid_q && res_q.status != php_pkg::STAT_OK) |->
        (res_q.payload_offset == '0 && res_q.pts_value == '0 && res_q.dts_value == '0);
  endproperty
  a_offset_only_ok: assert property (p_offset_only_ok) else $error("fields not cleared");

  property p_ok_offset_min;
    @(posedge clk_i) disable iff (!rst_ni)
      (valid_q && res_q.status == php_pkg::STAT_OK) |-> res_q.payload_offset >= 9'd9;
  endproperty
  a_ok_offset_min: assert property (p_ok_offset_min) else $error("bad payload offset");

endmodule

### hdl/pes_header_parser_core.sv
// ----------------------------------------------------------------------------
// pes_header_parser_core
// mpeg-2 pes header parser: one packet byte per beat in, one result beat out
// per packet on its last byte
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid / s_axis_tready data_byte in tdata, last_byte in tlast
//  m_axis    out  m_axis_tvalid / m_axis_tready result fields in tdata
//
//  one byte per cycle sustained while the record queue is not full
//  each byte updates the capture registers; the last byte pushes the record
//  into a two-entry record queue, and the result register presents the beat
//  s_axis_tready drops only while the record queue is full
//  reset returns all counters and captured fields to zero
// ----------------------------------------------------------------------------
module pes_header_parser_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // data_byte
  input  logic                         s_axis_tlast,   // last_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [php_pkg::OUT_BITS-1:0] m_axis_tdata    // status, stream_id, pes_length,
                                                       // scrambling, flag_bits,
                                                       // pts_value, dts_value,
                                                       // payload_offset,
                                                       // payload_length, zero pad
);

  logic              beat, push, pop, q_full, q_empty;
  php_pkg::php_rec_t rec_in, rec_out;
  php_pkg::php_res_t res;

  assign s_axis_tready = !q_full;
  assign beat          = s_axis_tvalid && s_axis_tready;

  php_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .byte_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .push_o (push),
    .rec_o  (rec_in)
  );

  php_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (pop),
    .rec_o   (rec_out)
  );

  php_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .rec_i   (rec_out),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {1'b0, res};

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// pes header parser bench: random and directed packets are streamed in one
// byte per beat, and every result beat is checked field by field against a
// byte-level predictor held in a scoreboard class
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] PTS_FLAG = 8'h80;
  localparam logic [7:0] DTS_FLAG = 8'h40;
  localparam int unsigned PAYLEN_LIMIT = 131071;
  localparam int LIMIT_NS = 4_000_000;

  class header_scoreboard;
    logic [php_pkg::COUNT_BITS-1:0] count;
    logic [7:0]                     sid;
    logic [15:0]                    len16;
    logic [7:0]                     ext;
    logic [7:0]                     ptsdts;
    logic [7:0]                     hdr_len;
    logic [7:0]                     stamp_a [5];
    logic [7:0]                     stamp_b [5];
    php_pkg::php_res_t              expected_results [$];
    int                             mismatches;
    int                             results_seen;

    function new();
      mismatches   = 0;
      results_seen = 0;
      clear();
    endfunction

    function void clear();
      count   = '0;
      sid     = '0;
      len16   = '0;
      ext     = '0;
      ptsdts  = '0;
      hdr_len = '0;
      foreach (stamp_a[i]) stamp_a[i] = '0;
      foreach (stamp_b[i]) stamp_b[i] = '0;
    endfunction

    function logic [32:0] stamp_value(logic [7:0] s [5]);
      return {s[0][3:1], s[1], s[2][7:1], s[3], s[4][7:1]};
    endfunction

    function void predict_byte(logic [7:0] b, logic lst);
      php_pkg::php_res_t r;
      int unsigned       total;
      int unsigned       poff;
      int unsigned       plen;
      if (count == 3) sid = b;
      else if (count == 4) len16[15:8] = b;
      else if (count == 5) len16[7:0] = b;
      else if (count == 6) ext = b;
      else if (count == 7) ptsdts = b;
      else if (count == 8) hdr_len = b;
      else if (count >= 9 && count <= 13) stamp_a[count - 9] = b;
      else if (count >= 14 && count <= 18) stamp_b[count - 14] = b;
      if (count != php_pkg::CNT_MAX) count++;
      if (!lst) return;
      r = '0;
      total = count;
      r.stream_id  = sid;
      r.pes_length = len16;
      if (total <= 6) begin
        r.status     = php_pkg::STAT_SHORT_PKT;
        r.stream_id  = '0;
        r.pes_length = '0;
      end else if (sid < php_pkg::SID_PRIV1 || sid == php_pkg::SID_PADDING ||
                   sid == php_pkg::SID_PRIV2 || sid > php_pkg::SID_LAST) begin
        r.status = php_pkg::STAT_NO_OPT;
      end else if (total < 9) begin
        r.status = php_pkg::STAT_SHORT_EXT;
      end else begin
        r.scrambling = ext[5:4];
        r.flag_bits  = {ext[3:0], ptsdts[7:6]};
        if (total - 9 < hdr_len) begin
          r.status = php_pkg::STAT_SHORT_HDR;
        end else begin
          r.status = php_pkg::STAT_OK;
          if ((ptsdts & PTS_FLAG) != 0) begin
            r.pts_value = stamp_value(stamp_a);
            if ((ptsdts & DTS_FLAG) != 0) r.dts_value = stamp_value(stamp_b);
          end else if ((ptsdts & DTS_FLAG) != 0) begin
            r.dts_value = stamp_value(stamp_a);
          end
          poff = 9 + hdr_len;
          r.payload_offset = 9'(poff);
          if (len16 != 0) begin
            plen = len16;
          end else begin
            plen = total - poff;
            if (plen > PAYLEN_LIMIT) plen = PAYLEN_LIMIT;
          end
          r.payload_length = 17'(plen);
        end
      end
      expected_results.push_back(r);
      clear();
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_result(logic [127:0] data);
      php_pkg::php_res_t want;
      php_pkg::php_res_t got;
      results_seen++;
      got = php_pkg::php_res_t'(data[$bits(php_pkg::php_res_t)-1:0]);
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected: %0h", data);
        return;
      end
      want = expected_results.pop_front();
      compare("status", want.status, got.status);
      compare("stream_id", want.stream_id, got.stream_id);
      compare("pes_length", want.pes_length, got.pes_length);
      compare("scrambling", want.scrambling, got.scrambling);
      compare("flag_bits", want.flag_bits, got.flag_bits);
      compare("pts_value", want.pts_value, got.pts_value);
      compare("dts_value", want.dts_value, got.dts_value);
      compare("payload_offset", want.payload_offset, got.payload_offset);
      compare("payload_length", want.payload_length, got.payload_length);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  header_scoreboard board = new();
  logic [7:0]       pkt_bytes [$];
  int               beats_sent = 0;

  always #6 clk_i = ~clk_i;

  pes_header_parser_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // start code, id, length, flags, header length, then header data and payload
  function automatic void build_packet(input logic [7:0] sid, input logic [15:0] len16,
                                       input logic [7:0] ext, input logic [7:0] flags,
                                       input logic [7:0] hdr, input int total,
                                       input int fill);
    logic [7:0] b;
    pkt_bytes.delete();
    for (int i = 0; i < total; i++) begin
      case (i)
        0, 1:    b = 8'h00;
        2:       b = 8'h01;
        3:       b = sid;
        4:       b = len16[15:8];
        5:       b = len16[7:0];
        6:       b = ext;
        7:       b = flags;
        8:       b = hdr;
        default: b = (fill < 0) ? 8'($urandom) : 8'(fill);
      endcase
      pkt_bytes.push_back(b);
    end
  endfunction

  function automatic void build_random_packet();
    int         kind;
    int         hdr;
    int         total;
    logic [7:0] sid;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      sid = ($urandom_range(0, 4) == 0) ? php_pkg::SID_PRIV1 :
                                          8'($urandom_range(8'hC0, php_pkg::SID_LAST));
      hdr = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10);
      total = 9 + hdr + $urandom_range(0, 8);
      if ($urandom_range(0, 7) == 0) total = $urandom_range(7, 9 + hdr);
      build_packet(sid, ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom),
                   8'($urandom), 8'($urandom), 8'(hdr), total, -1);
    end else if (kind == 7) begin
      build_packet(8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom_range(0, 12)), $urandom_range(7, 16), -1);
    end else if (kind == 8) begin
      build_packet(8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), $urandom_range(1, 8), -1);
    end else begin
      pkt_bytes.delete();
      total = $urandom_range(1, 24);
      repeat (total) pkt_bytes.push_back(8'($urandom));
    end
  endfunction

  task automatic send_beat(input logic [7:0] d, input logic lst, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    board.predict_byte(d, lst);
    beats_sent++;
  endtask

  task automatic send_packet(input bit quiet);
    foreach (pkt_bytes[i])
      send_beat(pkt_bytes[i], i == pkt_bytes.size() - 1, quiet ? 0 : rand_gap());
  endtask

  task automatic send_directed(input logic [7:0] sid, input logic [15:0] len16,
                               input logic [7:0] ext, input logic [7:0] flags,
                               input logic [7:0] hdr, input int total, input int fill);
    build_packet(sid, len16, ext, flags, hdr, total, fill);
    send_packet($urandom_range(0, 3) == 0);
  endtask

  initial begin : reset_gen
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : stimulus
    @(posedge rst_ni);
    @(posedge clk_i);
    // marker cut short, short packets
    send_directed(8'hE0, 16'h0010, 8'h00, 8'h00, 8'h00, 1, -1);
    send_directed(8'hE0, 16'h0010, 8'h00, 8'h00, 8'h00, 6, -1);
    // ids without optional header
    send_directed(8'hBC, 16'h0001, 8'hFF, 8'hFF, 8'h00, 7, -1);
    send_directed(php_pkg::SID_PADDING, 16'h0006, 8'h80, 8'hC0, 8'h00, 12, -1);
    send_directed(php_pkg::SID_PRIV2, 16'h0003, 8'h80, 8'h80, 8'h00, 9, -1);
    send_directed(8'hF0, 16'h0000, 8'h81, 8'hC0, 8'h02, 14, -1);
    send_directed(8'h00, 16'hFFFF, 8'h84, 8'h80, 8'h05, 20, -1);
    send_directed(8'hFF, 16'h0000, 8'h84, 8'h80, 8'h05, 20, -1);
    // short extension, short header data
    send_directed(php_pkg::SID_PRIV1, 16'h0001, 8'hFF, 8'hFF, 8'h00, 7, -1);
    send_directed(php_pkg::SID_LAST, 16'h0002, 8'hFF, 8'hFF, 8'h00, 8, -1);
    send_directed(8'hC0, 16'h0004, 8'hB5, 8'h80, 8'h05, 10, -1);
    // timestamp placement
    send_directed(8'hE0, 16'h0020, 8'h8F, 8'h80, 8'h05, 20, -1);
    send_directed(8'hE0, 16'h0000, 8'hA3, 8'hC0, 8'h0A, 24, -1);
    send_directed(8'hE0, 16'h0000, 8'h90, 8'h40, 8'h05, 18, -1);
    send_directed(php_pkg::SID_PRIV1, 16'h0000, 8'h80, 8'hC0, 8'h0A, 24, 8'hFF);
    send_directed(php_pkg::SID_LAST, 16'h0000, 8'h80, 8'h00, 8'h00, 9, -1);
    // stamp bytes past the packet end
    send_directed(8'hE0, 16'h0000, 8'h80, 8'hC0, 8'h00, 11, 8'hFF);
    send_directed(8'hE0, 16'h0000, 8'h80, 8'h40, 8'h00, 15, 8'hFF);
    send_directed(8'hE0, 16'hFFFF, 8'hFF, 8'hFF, 8'h03, 16, -1);
    // largest header length, complete and cut short
    send_directed(8'hE0, 16'h0000, 8'h80, 8'hC0, 8'hFF, 270, -1);
    send_directed(8'hC0, 16'h0000, 8'h80, 8'hC0, 8'hFF, 263, -1);
    send_directed(8'hE0, 16'h0000, 8'h80, 8'h00, 8'h02, 13, -1);

    while (beats_sent < 1150) begin
      build_random_packet();
      send_packet($urandom_range(0, 3) == 0);
    end
    s_axis_tvalid <= 1'b0;
    while (board.pending() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    int span;
    bit quiet;
    bit held;
    stall_left = 0;
    span = 0;
    quiet = 1'b0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      // one long hold-off so the record queue fills and input backs up
      if (!held && board.results_seen >= 10) begin
        held = 1'b1;
        stall_left = 400;
      end
      if (span == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        span = $urandom_range(50, 300);
      end else begin
        span--;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet) stall_left = rand_gap();
      end
    end
  end

  initial begin : watchdog
    #LIMIT_NS;
    $display("tb: failure");
    $finish;
  end

endmodule
